// ===== rtl/acir_pkg.sv =====
// Package for the air-conditioner IR command frame encoder.
// Holds frame constants, code tables and the BCD helper; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acir_pkg;

    localparam int IN_BYTES  = 7;
    localparam int OUT_BYTES = 9;

    // Frame constants
    localparam logic [7:0] FRAME_HEADER = 8'h16;
    localparam int         BODY_BITS    = 60;
    localparam int         NIB_GROUP    = 5;

    // Mode selector values
    localparam logic [2:0] MODE_COOL = 3'd0;
    localparam logic [2:0] MODE_DRY  = 3'd1;
    localparam logic [2:0] MODE_FAN  = 3'd2;
    localparam logic [2:0] MODE_HEAT = 3'd3;
    localparam logic [2:0] MODE_AUTO = 3'd4;

    // Fan selector values
    localparam logic [2:0] FAN_AUTO   = 3'd0;
    localparam logic [2:0] FAN_MIN    = 3'd1;
    localparam logic [2:0] FAN_MEDIUM = 3'd2;
    localparam logic [2:0] FAN_MAX    = 3'd3;
    localparam logic [2:0] FAN_QUIET  = 3'd4;
    localparam logic [2:0] FAN_TURBO  = 3'd5;

    // Frame bits 0..59, before the checksum goes on top
    typedef logic [BODY_BITS-1:0] frame_body_t;
    typedef logic [7:0]           bcd_byte_t;

    function automatic logic [3:0] mode_code(input logic [2:0] sel);
        logic [3:0] code;
        case (sel)
            MODE_COOL: code = 4'h2;
            MODE_DRY:  code = 4'h1;
            MODE_FAN:  code = 4'h4;
            MODE_HEAT: code = 4'h8;
            MODE_AUTO: code = 4'hA;
            default:   code = 4'h0;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] fan_code(input logic [2:0] sel);
        logic [3:0] code;
        case (sel)
            FAN_AUTO:   code = 4'h1;
            FAN_MIN:    code = 4'h8;
            FAN_MEDIUM: code = 4'h4;
            FAN_MAX:    code = 4'h2;
            FAN_QUIET:  code = 4'h9;
            FAN_TURBO:  code = 4'h3;
            default:    code = 4'h0;
        endcase
        return code;
    endfunction

    // Two BCD digits of a value below 64: tens by multiply-by-reciprocal
    // (13/128 is exact for this range), units by subtraction.
    function automatic bcd_byte_t bcd2(input logic [5:0] v);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [5:0] units;
        prod  = {4'b0, v} * 10'd13;
        tens  = prod[9:7];
        units = v - ({3'b0, tens} * 6'd10);
        return {1'b0, tens, units[3:0]};
    endfunction

endpackage : acir_pkg

`default_nettype wire

// ===== rtl/ac_ir_command_frame_encoder_core.sv =====
// Top level of the air-conditioner IR command frame encoder.
// Depends on acir_pkg for code tables, BCD conversion and frame constants.
`timescale 1ns / 1ps
`default_nettype none

//------------------------------------------------------------------------------
// One air-conditioner command comes in on the s_axis stream and one 64-bit
// IR frame (bit 0 sent first) plus its 4-bit checksum leaves on m_axis.
// A request is accepted on a rising edge with tvalid and tready both high.
//
// Pipeline: three register stages.
//   stage 1  BCD conversion of times and temperature, mode/fan code lookup,
//            assembly of frame bits 0..59
//   stage 2  three partial nibble sums (five nibbles each, mod 16)
//   stage 3  final checksum add, output register driving m_axis
// m_axis_tvalid rises once a request has passed through stages 1, 2 and 3
// in turn. Throughput is one request per cycle while m_axis does not stall;
// each stage advances whenever the stage after it is empty or moving,
// so bubbles collapse and a stall on m_axis only blocks s_axis once all
// three stages hold data.
//
// Reset (rst_n low, asynchronous) empties the pipeline; the block carries
// no other state. When the receiver stalls, the output holds its frame and
// the stages behind it fill, then s_axis_tready drops.
//------------------------------------------------------------------------------
module ac_ir_command_frame_encoder_core
    import acir_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [4:0] clock_hours, [10:5] clock_minutes, [15:11] target_temperature,
    // [18:16] operating_mode, [21:19] fan_speed, [24:22] option_flags,
    // [25] on_timer_enabled, [30:26] on_timer_hours, [36:31] on_timer_minutes,
    // [37] off_timer_enabled, [42:38] off_timer_hours,
    // [48:43] off_timer_minutes, [55:49] zero
    input  wire logic [IN_BYTES*8-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [63:0] frame_word, [67:64] frame_checksum, [71:68] zero
    output logic [OUT_BYTES*8-1:0]      m_axis_tdata
);

    // Unpack the command
    logic [4:0] clock_hours;
    logic [5:0] clock_minutes;
    logic [4:0] target_temperature;
    logic [2:0] operating_mode;
    logic [2:0] fan_speed;
    logic [2:0] option_flags;
    logic       on_timer_enabled;
    logic [4:0] on_timer_hours;
    logic [5:0] on_timer_minutes;
    logic       off_timer_enabled;
    logic [4:0] off_timer_hours;
    logic [5:0] off_timer_minutes;

    assign clock_hours        = s_axis_tdata[4:0];
    assign clock_minutes      = s_axis_tdata[10:5];
    assign target_temperature = s_axis_tdata[15:11];
    assign operating_mode     = s_axis_tdata[18:16];
    assign fan_speed          = s_axis_tdata[21:19];
    assign option_flags       = s_axis_tdata[24:22];
    assign on_timer_enabled   = s_axis_tdata[25];
    assign on_timer_hours     = s_axis_tdata[30:26];
    assign on_timer_minutes   = s_axis_tdata[36:31];
    assign off_timer_enabled  = s_axis_tdata[37];
    assign off_timer_hours    = s_axis_tdata[42:38];
    assign off_timer_minutes  = s_axis_tdata[48:43];

    // Stage registers
    logic         s1_valid_reg, s1_valid_next;
    frame_body_t  s1_body_reg;
    logic         s2_valid_reg, s2_valid_next;
    frame_body_t  s2_body_reg;
    logic [3:0]   s2_psum_reg [3];
    logic         s3_valid_reg, s3_valid_next;
    frame_body_t  s3_body_reg;
    logic [3:0]   s3_sum_reg;

    // Stage advance: a stage loads when it is empty or its content moves on
    logic s3_load, s2_load, s1_load;

    assign s3_load       = !s3_valid_reg || m_axis_tready;
    assign s2_load       = !s2_valid_reg || s3_load;
    assign s1_load       = !s1_valid_reg || s2_load;
    assign s_axis_tready = s1_load;

    assign s1_valid_next = s1_load ? s_axis_tvalid : s1_valid_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg  : s2_valid_reg;
    assign s3_valid_next = s3_load ? s2_valid_reg  : s3_valid_reg;

    // Stage 1: assemble frame bits 0..59
    frame_body_t body_next;
    bcd_byte_t   on_bcd;
    bcd_byte_t   off_bcd;

    always_comb
    begin
        on_bcd    = bcd2({1'b0, on_timer_hours});
        off_bcd   = bcd2({1'b0, off_timer_hours});
        body_next = '0;
        body_next[7:0]   = FRAME_HEADER;
        body_next[11:8]  = mode_code(operating_mode);
        body_next[15:12] = fan_code(fan_speed);
        body_next[23:16] = bcd2(clock_minutes);
        body_next[31:24] = bcd2({1'b0, clock_hours});
        // hour tens digit stays below 4, so the BCD fits in six bits
        body_next[37:32] = on_bcd[5:0];
        body_next[38]    = (on_timer_minutes != 6'd0);
        body_next[39]    = on_timer_enabled;
        body_next[45:40] = off_bcd[5:0];
        body_next[46]    = (off_timer_minutes != 6'd0);
        body_next[47]    = off_timer_enabled;
        body_next[55:48] = bcd2({1'b0, target_temperature});
        body_next[56]    = option_flags[1];
        body_next[57]    = option_flags[0];
        body_next[58]    = 1'b1;
        body_next[59]    = option_flags[2];
    end

    // Stage 2: three partial sums of five nibbles each, kept mod 16
    logic [3:0] psum_next [3];

    always_comb
    begin
        for (int g = 0; g < 3; g++)
        begin
            psum_next[g] = 4'd0;
            for (int n = 0; n < NIB_GROUP; n++)
            begin
                psum_next[g] = psum_next[g] + s1_body_reg[(g*NIB_GROUP+n)*4 +: 4];
            end
        end
    end

    logic [3:0] sum_next;
    assign sum_next = s2_psum_reg[0] + s2_psum_reg[1] + s2_psum_reg[2];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Payload registers: hold while stalled, load on advance
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_body_reg <= body_next;
        end
        if (s2_load)
        begin
            s2_body_reg <= s1_body_reg;
            for (int g = 0; g < 3; g++)
            begin
                s2_psum_reg[g] <= psum_next[g];
            end
        end
        if (s3_load)
        begin
            s3_body_reg <= s2_body_reg;
            s3_sum_reg  <= sum_next;
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = {4'b0, s3_sum_reg, s3_sum_reg, s3_body_reg};

`ifndef NO_ASSERTIONS
    // Checksum nibble of the frame and the separate checksum field agree
    a_sum_copy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:60] == m_axis_tdata[67:64]))
        else $error("frame checksum nibble differs from checksum field");

    // Every frame leaves with the fixed header and the constant-one bit
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] == FRAME_HEADER && m_axis_tdata[58]))
        else $error("frame header or constant bit corrupted");

    // Input is refused only when every stage holds an item
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("input stalled with a free pipeline stage");

    // An item in stage 2 moves to the output when stage 3 is free
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_valid_reg) |=> s3_valid_reg)
        else $error("stage 2 item failed to advance into a free stage 3");
`endif

endmodule : ac_ir_command_frame_encoder_core

`default_nettype wire

// ===== tb/sv/ac_ir_command_frame_encoder_core_checker.sv =====
`timescale 1ns / 1ps
// Frame checker for the IR command frame encoder: watches both stream channels,
// predicts each 64-bit frame and checksum, and compares in order.
// Depends on acir_pkg for mode/fan selector names, the frame header and bus widths.

module ac_ir_frame_checker
    import acir_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [IN_BYTES*8-1:0]     s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [OUT_BYTES*8-1:0]    m_tdata,
    output int                        fail_count,
    output int                        frames_checked,
    output int                        pending_frames
);

    localparam int SLEEP_BIT = 0;
    localparam int SWING_BIT = 1;
    localparam int POWER_BIT = 2;

    // Command as it sits in s_tdata, first field in the lowest bits
    typedef struct packed {
        logic [6:0] pad;
        logic [5:0] off_minutes;
        logic [4:0] off_hours;
        logic       off_enable;
        logic [5:0] on_minutes;
        logic [4:0] on_hours;
        logic       on_enable;
        logic [2:0] options;
        logic [2:0] fan;
        logic [2:0] mode;
        logic [4:0] temperature;
        logic [5:0] minutes;
        logic [4:0] hours;
    } command_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [3:0]  checksum;
        logic [63:0] word;
    } frame_t;

    frame_t expected_frames[$];
    int     mismatch_total;
    int     checked_total;

    assign fail_count     = mismatch_total;
    assign frames_checked = checked_total;

    // Tens and units digit, each in its own nibble; out-of-range values split the same way
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [3:0] units;
        tens  = 4'(v / 10);
        units = 4'(v % 10);
        return {tens, units};
    endfunction

    function automatic frame_t encode_frame(input command_t c);
        logic [63:0] w;
        logic [3:0]  sum;
        logic [3:0]  mode_nib;
        logic [3:0]  fan_nib;
        logic [7:0]  on_bcd;
        logic [7:0]  off_bcd;
        frame_t      f;
        case (c.mode)
            MODE_COOL: mode_nib = 4'h2;
            MODE_DRY:  mode_nib = 4'h1;
            MODE_FAN:  mode_nib = 4'h4;
            MODE_HEAT: mode_nib = 4'h8;
            MODE_AUTO: mode_nib = 4'hA;
            default:   mode_nib = 4'h0;
        endcase
        case (c.fan)
            FAN_AUTO:   fan_nib = 4'h1;
            FAN_MIN:    fan_nib = 4'h8;
            FAN_MEDIUM: fan_nib = 4'h4;
            FAN_MAX:    fan_nib = 4'h2;
            FAN_QUIET:  fan_nib = 4'h9;
            FAN_TURBO:  fan_nib = 4'h3;
            default:    fan_nib = 4'h0;
        endcase
        on_bcd  = to_bcd({1'b0, c.on_hours});
        off_bcd = to_bcd({1'b0, c.off_hours});
        w = '0;
        w[7:0]   = FRAME_HEADER;
        w[11:8]  = mode_nib;
        w[15:12] = fan_nib;
        w[23:16] = to_bcd(c.minutes);
        w[31:24] = to_bcd({1'b0, c.hours});
        w[37:32] = on_bcd[5:0];
        w[38]    = (c.on_minutes != '0);
        w[39]    = c.on_enable;
        w[45:40] = off_bcd[5:0];
        w[46]    = (c.off_minutes != '0);
        w[47]    = c.off_enable;
        w[55:48] = to_bcd({1'b0, c.temperature});
        w[56]    = c.options[SWING_BIT];
        w[57]    = c.options[SLEEP_BIT];
        w[58]    = 1'b1;
        w[59]    = c.options[POWER_BIT];
        sum = '0;
        for (int i = 0; i < 15; i++)
            sum += w[i*4 +: 4];
        w[63:60]   = sum;
        f.pad      = '0;
        f.checksum = sum;
        f.word     = w;
        return f;
    endfunction

    // Print one line per mismatch and count every one
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_total++;
        $display("[%0t] frame %0d %s: got %h, want %h",
                 $time, checked_total, what, got, want);
    endtask

    initial
    begin
        mismatch_total = 0;
        checked_total  = 0;
        pending_frames = 0;
    end

    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_frames.size() == 0)
                    report_mismatch("unexpected frame", got.word, '0);
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.word !== want.word)
                        report_mismatch("frame_word", got.word, want.word);
                    if (got.checksum !== want.checksum)
                        report_mismatch("frame_checksum", 64'(got.checksum),
                                        64'(want.checksum));
                    if (got.pad !== want.pad)
                        report_mismatch("tdata padding", 64'(got.pad), 64'(want.pad));
                    checked_total++;
                end
            end
            if (s_tvalid && s_tready)
                expected_frames.push_back(encode_frame(s_tdata));
        end
        pending_frames <= expected_frames.size();
    end

endmodule

// ===== tb/sv/ac_ir_command_frame_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the IR command frame encoder testbench: clock, reset, command stimulus,
// output back-pressure and the verdict. Needs acir_pkg, the encoder core and
// ac_ir_frame_checker.

module ac_ir_command_frame_encoder_core_tb;
    import acir_pkg::*;

    localparam int HOLD_CYCLES   = 60;   // long output stall to fill the pipeline
    localparam int BURST_ITEMS   = 20;   // requests offered during that stall
    localparam int PHASE_ITEMS   = 200;  // random requests per idle mix
    localparam int DRAIN_LIMIT   = 2000;
    localparam int LATENCY_SLACK = 8;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_BYTES*8-1:0]    s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_BYTES*8-1:0]   m_axis_tdata;

    int fail_count;
    int frames_checked;
    int pending_frames;

    int send_idle_pct;       // owned by the stimulus process
    int recv_idle_pct;       // read by the receiver process, written with <=
    logic stall_toggle;      // flip to ask the receiver for a long hold
    int sent_total;
    int directed_total;

    ac_ir_command_frame_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ac_ir_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .fail_count     (fail_count),
        .frames_checked (frames_checked),
        .pending_frames (pending_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the pipeline hangs; far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout: %0d frames still outstanding", pending_frames);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random back-pressure, plus a long counted hold on request
    initial
    begin
        logic stall_seen;
        int   hold_left;
        stall_seen    = 1'b0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_toggle != stall_seen)
            begin
                stall_seen = stall_toggle;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Pack fields into s_axis_tdata, clock_hours in the lowest bits
    function automatic logic [IN_BYTES*8-1:0] pack_command(
        input logic [4:0] hours,      input logic [5:0] minutes,
        input logic [4:0] temp,       input logic [2:0] mode,
        input logic [2:0] fan,        input logic [2:0] options,
        input logic       on_enable,  input logic [4:0] on_hours,
        input logic [5:0] on_minutes, input logic       off_enable,
        input logic [4:0] off_hours,  input logic [5:0] off_minutes);
        return {7'b0, off_minutes, off_hours, off_enable, on_minutes, on_hours,
                on_enable, options, fan, mode, temp, minutes, hours};
    endfunction

    // Mostly in-range values; one in four spans the whole field width
    function automatic int pick(input int bits, input int lo, input int hi);
        if ($urandom_range(3) == 0)
            return $urandom_range((1 << bits) - 1);
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [IN_BYTES*8-1:0] random_command();
        return pack_command(5'(pick(5, 0, 23)), 6'(pick(6, 0, 59)),
                            5'(pick(5, 16, 30)), 3'(pick(3, 0, 4)),
                            3'(pick(3, 0, 5)), 3'($urandom_range(7)),
                            1'($urandom_range(1)), 5'(pick(5, 0, 23)),
                            6'(pick(6, 0, 59)), 1'($urandom_range(1)),
                            5'(pick(5, 0, 23)), 6'(pick(6, 0, 59)));
    endfunction

    // Offer one request after a random gap; hold tvalid high across back-to-back requests
    task automatic send_command(input logic [IN_BYTES*8-1:0] cmd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_total++;
    endtask

    // Drop tvalid and wait until every predicted frame has come out, or until DRAIN_LIMIT runs out
    task automatic drain_frames();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_frames != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        stall_toggle   = 1'b0;
        send_idle_pct  = 8;
        recv_idle_pct  = 68;
        sent_total     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range extremes, every mode and fan selector, option bits
        send_command(pack_command(0, 0, 16, MODE_COOL, FAN_AUTO, 0, 0, 0, 0, 0, 0, 0));
        send_command(pack_command(23, 59, 30, MODE_AUTO, FAN_TURBO, 7,
                                  1, 23, 59, 1, 23, 59));
        // Selectors 0..7, including the unused mode and fan codes that map to zero
        for (int i = 0; i < 8; i++)
            send_command(pack_command(5'(i * 3), 6'(i * 7), 5'(16 + i * 2), 3'(i), 3'(i),
                                      3'(i), 1'(i % 2), 5'(i * 3), 6'(i * 8),
                                      1'((i + 1) % 2), 5'(23 - i), 6'(59 - i * 8)));
        // Fan mode with auto, quiet and turbo fan is passed through, not refused
        send_command(pack_command(7, 5, 22, MODE_FAN, FAN_AUTO, 0, 0, 0, 0, 0, 0, 0));
        send_command(pack_command(8, 15, 24, MODE_FAN, FAN_QUIET, 2, 1, 5, 0, 0, 0, 0));
        send_command(pack_command(9, 45, 26, MODE_FAN, FAN_TURBO, 4, 0, 0, 0, 1, 6, 1));
        // Out-of-range values still split into tens and units digits
        send_command(pack_command(31, 63, 31, 7, 7, 7, 1, 31, 63, 1, 31, 63));
        send_command(pack_command(24, 60, 15, MODE_HEAT, FAN_MAX, 0, 1, 24, 60, 0, 24, 0));
        send_command(pack_command(12, 30, 0, MODE_DRY, FAN_MIN, 1, 0, 12, 1, 1, 0, 30));
        // One option bit at a time
        send_command(pack_command(1, 1, 20, MODE_COOL, FAN_MEDIUM, 2, 0, 0, 0, 0, 0, 0));
        send_command(pack_command(2, 2, 21, MODE_HEAT, FAN_MIN, 4, 0, 0, 0, 0, 0, 0));
        directed_total = sent_total;

        // Long output hold while requests keep coming: pipeline fills, s_axis stalls
        send_idle_pct = 0;
        stall_toggle <= ~stall_toggle;
        for (int i = 0; i < BURST_ITEMS; i++)
            send_command(random_command());
        drain_frames();

        // Random: sender mostly busy, receiver mostly stalled
        send_idle_pct = 8;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_command(random_command());
        drain_frames();

        // Swap the idle mix
        send_idle_pct = 68;
        recv_idle_pct <= 8;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_command(random_command());
        drain_frames();

        // Full rate both ways
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_command(random_command());
        drain_frames();

        // Let any stray late frame show up before the verdict
        repeat (LATENCY_SLACK) @(posedge clk);

        $display("Sent %0d commands (%0d directed), %0d frames checked", sent_total,
                 directed_total, frames_checked);
        $display("Covered out-of-range fields, all selectors, a long output hold and three idle mixes");
        if (pending_frames != 0)
            $display("%0d expected frames never arrived", pending_frames);
        if (fail_count == 0 && pending_frames == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/acir_pkg.sv
rtl/ac_ir_command_frame_encoder_core.sv
tb/sv/ac_ir_command_frame_encoder_core_checker.sv
tb/sv/ac_ir_command_frame_encoder_core_tb.sv
